// ----- src/fccf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fccf_pkg;

   localparam int unsigned CHUNK_MAX = 1048576;
   localparam int unsigned POS_W     = $clog2(CHUNK_MAX) + 1;
   localparam int unsigned ID_W      = 32;
   localparam int unsigned HALO_W    = 16;

   localparam logic [7:0] NAME_MARK = 8'h3E;
   localparam logic [7:0] LINE_END  = 8'h0A;

   localparam logic REC_HEADER  = 1'b0;
   localparam logic REC_SUMMARY = 1'b1;

   typedef logic [POS_W-1:0] pos_type;
   typedef logic [ID_W-1:0]  id_type;

   typedef struct packed {
      logic    record_kind;
      id_type  sequence_id;
      pos_type cut_position;
      logic    cut_found;
      id_type  first_id;
      id_type  sequence_count;
      id_type  last_id;
      logic    run_last;
   } record_type;

endpackage

`default_nettype wire

// ----- src/fasta_chunk_cut_finder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// fasta chunk cut finder: scans one byte of a fasta chunk per request and keeps a
// running sequence count across chunks. a header ('>' up to its '\n') emits one
// header record with its global id; the chunk's last byte emits a summary record
// with the cut position, first id, count and last id, and may take back the last
// header when the final sequence is shorter than csr_halo_length. one request is
// taken every clock while the result buffer is empty after that clock's pop;
// all per-byte work is a single pass of compares and adds between the request
// port and a two-entry result buffer. a byte that yields two records (header
// end on the chunk's last byte) holds the request side while the buffer drains.
// the csr write is always ready and must only be issued while the block is idle.
module fasta_chunk_cut_finder (
   input  wire                   clock,
   input  wire                   reset,
   // configuration
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire  [15:0]           csr_halo_length,
   // byte requests
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  [7:0]            req_byte_value,
   input  wire                   req_chunk_end,
   // records
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic                  rsp_record_kind,
   output logic [31:0]           rsp_sequence_id,
   output logic [20:0]           rsp_cut_position,
   output logic                  rsp_cut_found,
   output logic [31:0]           rsp_first_id,
   output logic [31:0]           rsp_sequence_count,
   output logic [31:0]           rsp_last_id,
   output logic                  rsp_run_last
);
   import fccf_pkg::*;

   // configuration and scan state
   logic [HALO_W-1:0] halo_ff;
   pos_type           pos_ff, pos_in;
   logic              at_start_ff, at_start_in;
   logic              inside_ff, inside_in;
   pos_type           pending_ff, pending_in;
   pos_type           last_name_ff, last_name_in;
   pos_type           seq_start_ff, seq_start_in;
   logic              counted_ff, counted_in;
   id_type            total_ff, total_in;
   id_type            first_id_ff, first_id_in;

   // result buffer, slot 0 drives the rsp port
   record_type        slot0_ff, slot0_in;
   record_type        slot1_ff, slot1_in;
   logic [1:0]        cnt_ff, cnt_in;

   logic       accept;
   logic       pop;
   logic       is_mark;
   logic       is_lf;
   logic       hdr_done;
   pos_type    idx;
   pos_type    size;
   pos_type    seq_len;
   logic       short_tail;
   id_type     total_hdr;
   id_type     total_fin;
   pos_type    cut;
   logic       found;
   record_type hdr_rec;
   record_type sum_rec;

   assign csr_ready = 1'b1;

   assign pop       = (cnt_ff != 2'd0) && !rsp_stall;
   // take a byte only when the buffer is empty after this clock's pop
   assign req_stall = (cnt_ff == 2'd2) || ((cnt_ff == 2'd1) && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign is_mark = (req_byte_value == NAME_MARK);
   assign is_lf   = (req_byte_value == LINE_END);

   // offset saturates one below the chunk limit
   assign idx  = (pos_ff < pos_type'(CHUNK_MAX)) ? pos_ff : pos_type'(CHUNK_MAX - 1);
   assign size = idx + pos_type'(1);

   always_comb begin
      first_id_in  = first_id_ff;
      inside_in    = inside_ff;
      pending_in   = pending_ff;
      last_name_in = last_name_ff;
      seq_start_in = seq_start_ff;
      counted_in   = counted_ff;
      at_start_in  = at_start_ff;
      pos_in       = pos_ff;
      total_hdr    = total_ff;
      hdr_done     = 1'b0;

      // first id of the chunk, one back when the chunk opens mid-sequence
      if (at_start_ff) begin
         if (is_mark) begin
            first_id_in = total_ff;
         end else begin
            first_id_in = (total_ff != '0) ? total_ff - id_type'(1) : '0;
         end
         at_start_in = 1'b0;
      end

      if (inside_ff) begin
         if (is_lf) begin
            hdr_done     = 1'b1;
            total_hdr    = total_ff + id_type'(1);
            last_name_in = pending_ff;
            seq_start_in = size;
            counted_in   = 1'b1;
            inside_in    = 1'b0;
         end
      end else if (is_mark) begin
         inside_in  = 1'b1;
         pending_in = idx;
      end

      if (pos_ff < pos_type'(CHUNK_MAX)) begin
         pos_in = pos_ff + pos_type'(1);
      end
   end

   // chunk summary: unfinished header first, then a too-short last sequence
   assign seq_len    = size - seq_start_in;
   assign short_tail = seq_len < pos_type'(halo_ff);

   always_comb begin
      total_fin = total_hdr;
      priority if (inside_in) begin
         cut   = pending_in;
         found = 1'b1;
      end else if (counted_in && short_tail) begin
         cut       = last_name_in;
         found     = 1'b1;
         total_fin = total_hdr - id_type'(1);
      end else begin
         cut   = size;
         found = 1'b0;
      end
   end

   always_comb begin
      hdr_rec                = '0;
      hdr_rec.record_kind    = REC_HEADER;
      hdr_rec.sequence_id    = total_ff;
      hdr_rec.run_last       = !req_chunk_end;

      sum_rec                = '0;
      sum_rec.record_kind    = REC_SUMMARY;
      sum_rec.cut_position   = cut;
      sum_rec.cut_found      = found;
      sum_rec.first_id       = first_id_in;
      sum_rec.sequence_count = total_fin - first_id_in;
      sum_rec.last_id        = total_fin - id_type'(1);
      sum_rec.run_last       = 1'b1;
   end

   // buffer update
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_ff - {1'b0, pop};
      if (pop) begin
         slot0_in = slot1_ff;
      end
      if (accept) begin
         priority if (hdr_done) begin
            slot0_in = hdr_rec;
            slot1_in = sum_rec;
            cnt_in   = req_chunk_end ? 2'd2 : 2'd1;
         end else if (req_chunk_end) begin
            slot0_in = sum_rec;
            cnt_in   = 2'd1;
         end else begin
            cnt_in = cnt_ff - {1'b0, pop};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         halo_ff      <= '0;
         pos_ff       <= '0;
         at_start_ff  <= 1'b1;
         inside_ff    <= 1'b0;
         pending_ff   <= '0;
         last_name_ff <= '0;
         seq_start_ff <= '0;
         counted_ff   <= 1'b0;
         total_ff     <= '0;
         first_id_ff  <= '0;
         cnt_ff       <= 2'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            halo_ff <= csr_halo_length;
         end
         cnt_ff <= cnt_in;
         if (accept) begin
            first_id_ff <= first_id_in;
            if (req_chunk_end) begin
               // chunk done, clear per-chunk state
               total_ff     <= total_fin;
               pos_ff       <= '0;
               at_start_ff  <= 1'b1;
               inside_ff    <= 1'b0;
               pending_ff   <= '0;
               last_name_ff <= '0;
               seq_start_ff <= '0;
               counted_ff   <= 1'b0;
            end else begin
               total_ff     <= total_hdr;
               pos_ff       <= pos_in;
               at_start_ff  <= at_start_in;
               inside_ff    <= inside_in;
               pending_ff   <= pending_in;
               last_name_ff <= last_name_in;
               seq_start_ff <= seq_start_in;
               counted_ff   <= counted_in;
            end
         end
      end
   end

   // payload slots, no reset
   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_valid          = (cnt_ff != 2'd0);
   assign rsp_record_kind    = slot0_ff.record_kind;
   assign rsp_sequence_id    = slot0_ff.sequence_id;
   assign rsp_cut_position   = slot0_ff.cut_position;
   assign rsp_cut_found      = slot0_ff.cut_found;
   assign rsp_first_id       = slot0_ff.first_id;
   assign rsp_sequence_count = slot0_ff.sequence_count;
   assign rsp_last_id        = slot0_ff.last_id;
   assign rsp_run_last       = slot0_ff.run_last;

`ifndef ASSERT_OFF
   // a request is only taken when the buffer is empty after this clock's pop
   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      accept |-> ((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && !rsp_stall)))
      else $error("request accepted with results still queued");

   // a header record that is not the last of its byte is followed by its summary
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_record_kind == REC_HEADER) && !rsp_run_last)
      |=> (rsp_valid && (!$past(rsp_stall) ? (rsp_record_kind == REC_SUMMARY) : 1'b1)))
      else $error("summary missing after header record");

   // the chunk end returns the scanner to its start state
   a_chunk_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chunk_end) |=> (at_start_ff && !inside_ff && (pos_ff == '0)))
      else $error("chunk state not cleared at chunk end");
`endif

endmodule

`default_nettype wire
